// ===== hw/rtl/dltq_pkg.sv =====
package dltq_pkg;

	localparam int SLOTS    = 16;
	localparam int COALESCE = 8;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int IDX_W    = $clog2(SLOTS + 1);
	localparam int CNT_W    = $clog2(COALESCE + 1);
	localparam int CI_W     = (COALESCE > 1) ? $clog2(COALESCE) : 1;

	localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(SLOTS);

	localparam logic [1:0] KIND_ACCEPT = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_NOTIFY = 2'd2;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_CREATE = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] ticks;
		logic [7:0]  thread_id;
		logic [31:0] wake_mask;
		logic        periodic;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [7:0]  target_thread;
		logic [31:0] bits_out;
		logic        last;
	} rsp_t;

endpackage

// ===== hw/rtl/delta_list_timer_queue_top.sv =====
// Delta-list timer queue with up to SLOTS notification timers. A word is accepted when start is
// high and busy is low; each result word is shown on rsp for exactly one cycle with rsp_valid,
// and the receiver cannot stall it. The min_ticks register is written only while the block is
// idle. A create into an empty list writes the new entry as the head; otherwise it compares the
// new entry against the head and then walks the list entry by entry until it finds its place or
// reaches the tail. An expiry walks from the head to find the firing group, then for each fired
// timer reads it, coalesces its notification and reinserts it by the insert walk if it is
// periodic, then flushes the coalesced notifications one word each and rearms the countdown
// from the new head unless the list is left empty. Every list walk step goes through the single
// read port of the slot memories.
module delta_list_timer_queue_top
	import dltq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        rsp_valid,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	typedef enum logic [14:0] {
		ST_IDLE      = 15'h0001,
		ST_INS_START = 15'h0002,
		ST_INS_HEAD  = 15'h0004,
		ST_INS_WALK  = 15'h0008,
		ST_INS_WDATA = 15'h0010,
		ST_INS_FIX1  = 15'h0020,
		ST_INS_FIX2  = 15'h0040,
		ST_EXP_FIND  = 15'h0080,
		ST_EXP_NODE  = 15'h0100,
		ST_EXP_NODED = 15'h0200,
		ST_EXP_RET   = 15'h0400,
		ST_EXP_NEXT  = 15'h0800,
		ST_FLUSH     = 15'h1000,
		ST_ARM       = 15'h2000,
		ST_ARM_D     = 15'h4000
	} state_t;

	state_t state_q;

	idx_t        link_mem   [SLOTS];
	logic [31:0] delta_mem  [SLOTS];
	logic [7:0]  thread_mem [SLOTS];
	logic [31:0] mask_mem   [SLOTS];
	logic [31:0] period_mem [SLOTS];
	logic [63:0] due_mem    [SLOTS];

	idx_t        rd_link;
	logic [31:0] rd_delta;
	logic [7:0]  rd_thread;
	logic [31:0] rd_mask;
	logic [31:0] rd_period;
	logic [63:0] rd_due;

	logic [SLOTS-1:0] used_q;
	idx_t        head_q;
	logic [63:0] now_q;
	logic [31:0] countdown_q;
	logic [31:0] elapsed_q;
	logic        running_q;
	logic [15:0] min_ticks_q;

	idx_t        ins_k_q;
	logic [31:0] ins_t_q;
	logic        ins_exp_q;
	idx_t        walk_ev_q;
	logic [31:0] et_q;
	idx_t        link_hold_q;
	idx_t        nxt_q;
	logic [31:0] nxt_delta_q;
	logic        pred_q;
	logic [31:0] d_q;

	logic        find_first_q;
	idx_t        cur_q;
	idx_t        last_q;
	idx_t        ev_q;
	idx_t        node_nxt_q;
	logic        node_per_q;
	logic [63:0] due_new_q;

	logic [7:0]      mth_q   [COALESCE];
	logic [31:0]     mbits_q [COALESCE];
	logic [CNT_W-1:0] mcnt_q;
	logic [CNT_W-1:0] fl_idx_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	logic [SLOT_W-1:0] rd_addr;
	logic        link_we;
	idx_t        link_wa;
	idx_t        link_wd;
	logic        delta_we;
	idx_t        delta_wa;
	logic [31:0] delta_wd;

	logic        free_found;
	idx_t        free_k;
	logic        create_ok;
	logic [31:0] t_adj;
	logic [31:0] d_w;
	logic [31:0] dz_w;
	logic        hit;
	logic [CI_W-1:0] hidx;
	logic [63:0] diff_w;
	logic [31:0] ret_w;
	logic        wdata_go;

	assign busy      = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = (state_q == ST_IDLE);

	always_comb begin
		free_found = 1'b0;
		free_k     = NONE_IDX;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_k     = IDX_W'(i);
			end
		end
	end

	assign create_ok = (req.ticks != 32'd0) && (req.thread_id != 8'd0) &&
		(req.wake_mask != 32'd0) && free_found;
	assign t_adj = (req.ticks <= elapsed_q) ? 32'd1 : (req.ticks - elapsed_q);
	assign d_w   = ins_t_q - et_q;
	assign dz_w  = (d_w < {16'd0, min_ticks_q}) ? 32'd0 : d_w;
	assign diff_w = due_new_q - now_q;
	assign ret_w  = (due_new_q > now_q) ? diff_w[31:0] : 32'd1;
	assign wdata_go = ({1'b0, ins_t_q} > ({1'b0, et_q} + {1'b0, rd_delta}));

	always_comb begin
		hit  = 1'b0;
		hidx = '0;
		for (int i = 0; i < COALESCE; i++) begin
			if (!hit && (CNT_W'(i) < mcnt_q) && (mth_q[i] == rd_thread)) begin
				hit  = 1'b1;
				hidx = CI_W'(i);
			end
		end
	end

	always_comb begin
		case (state_q)
			ST_INS_WALK: rd_addr = link_hold_q[SLOT_W-1:0];
			ST_EXP_FIND: rd_addr = rd_link[SLOT_W-1:0];
			ST_EXP_NODE: rd_addr = ev_q[SLOT_W-1:0];
			default:     rd_addr = head_q[SLOT_W-1:0];
		endcase
	end

	always_comb begin
		link_we  = 1'b0;
		link_wa  = ins_k_q;
		link_wd  = NONE_IDX;
		delta_we = 1'b0;
		delta_wa = ins_k_q;
		delta_wd = ins_t_q;
		case (state_q)
			ST_INS_START: begin
				link_we  = (head_q == NONE_IDX);
				delta_we = (head_q == NONE_IDX);
			end
			ST_INS_FIX1: begin
				link_we  = 1'b1;
				link_wd  = nxt_q;
				delta_we = 1'b1;
				delta_wd = dz_w;
			end
			ST_INS_FIX2: begin
				link_we  = pred_q;
				link_wa  = walk_ev_q;
				link_wd  = ins_k_q;
				delta_we = (nxt_q != NONE_IDX);
				delta_wa = nxt_q;
				delta_wd = nxt_delta_q - d_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa[SLOT_W-1:0]] <= link_wd;
		end
		if (delta_we) begin
			delta_mem[delta_wa[SLOT_W-1:0]] <= delta_wd;
		end
		if (state_q == ST_IDLE && start && req.cmd == CMD_CREATE && create_ok) begin
			thread_mem[free_k[SLOT_W-1:0]] <= req.thread_id;
			mask_mem[free_k[SLOT_W-1:0]]   <= req.wake_mask;
			period_mem[free_k[SLOT_W-1:0]] <= req.periodic ? req.ticks : 32'd0;
			due_mem[free_k[SLOT_W-1:0]]    <= req.periodic ? (now_q + {32'd0, req.ticks}) :
				64'd0;
		end else if (state_q == ST_EXP_NODED && rd_period != 32'd0) begin
			due_mem[ev_q[SLOT_W-1:0]] <= rd_due + {32'd0, rd_period};
		end
		rd_link   <= link_mem[rd_addr];
		rd_delta  <= delta_mem[rd_addr];
		rd_thread <= thread_mem[rd_addr];
		rd_mask   <= mask_mem[rd_addr];
		rd_period <= period_mem[rd_addr];
		rd_due    <= due_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			head_q       <= NONE_IDX;
			now_q        <= 64'd0;
			countdown_q  <= 32'd0;
			elapsed_q    <= 32'd0;
			running_q    <= 1'b0;
			min_ticks_q  <= 16'd1;
			mcnt_q       <= '0;
			rsp_valid_q  <= 1'b0;
			ins_exp_q    <= 1'b0;
			pred_q       <= 1'b0;
			find_first_q <= 1'b0;
			fl_idx_q     <= '0;
		end else begin
			rsp_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				min_ticks_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (req.cmd == CMD_CREATE) begin
							rsp_valid_q         <= 1'b1;
							rsp_q.target_thread <= 8'd0;
							rsp_q.bits_out      <= 32'd0;
							rsp_q.last          <= 1'b1;
							if (create_ok) begin
								rsp_q.kind         <= KIND_ACCEPT;
								rsp_q.slot         <= 4'(free_k);
								used_q[free_k[SLOT_W-1:0]] <= 1'b1;
								ins_k_q   <= free_k;
								ins_t_q   <= t_adj;
								ins_exp_q <= 1'b0;
								state_q   <= ST_INS_START;
							end else begin
								rsp_q.kind <= KIND_REJECT;
								rsp_q.slot <= 4'd0;
							end
						end else begin
							now_q <= now_q + 64'd1;
							if (running_q && countdown_q != 32'd0) begin
								elapsed_q   <= elapsed_q + 32'd1;
								countdown_q <= countdown_q - 32'd1;
								if (countdown_q == 32'd1) begin
									running_q <= 1'b0;
									elapsed_q <= 32'd0;
									if (head_q != NONE_IDX) begin
										mcnt_q       <= '0;
										find_first_q <= 1'b1;
										cur_q        <= head_q;
										ev_q         <= head_q;
										state_q      <= ST_EXP_FIND;
									end
								end
							end
						end
					end
				end
				ST_INS_START: begin
					if (head_q == NONE_IDX) begin
						head_q      <= ins_k_q;
						countdown_q <= ins_t_q;
						elapsed_q   <= 32'd0;
						running_q   <= 1'b1;
						state_q     <= ins_exp_q ? ST_EXP_NEXT : ST_IDLE;
					end else begin
						state_q <= ST_INS_HEAD;
					end
				end
				ST_INS_HEAD: begin
					if (ins_t_q < rd_delta) begin
						nxt_q       <= head_q;
						nxt_delta_q <= rd_delta;
						head_q      <= ins_k_q;
						countdown_q <= ins_t_q;
						elapsed_q   <= 32'd0;
						running_q   <= 1'b1;
						pred_q      <= 1'b0;
						et_q        <= 32'd0;
						state_q     <= ST_INS_FIX1;
					end else begin
						walk_ev_q   <= head_q;
						et_q        <= rd_delta;
						link_hold_q <= rd_link;
						pred_q      <= 1'b1;
						state_q     <= ST_INS_WALK;
					end
				end
				ST_INS_WALK: begin
					if (link_hold_q == NONE_IDX) begin
						nxt_q   <= NONE_IDX;
						state_q <= ST_INS_FIX1;
					end else begin
						state_q <= ST_INS_WDATA;
					end
				end
				ST_INS_WDATA: begin
					if (wdata_go) begin
						walk_ev_q   <= link_hold_q;
						et_q        <= et_q + rd_delta;
						link_hold_q <= rd_link;
						state_q     <= ST_INS_WALK;
					end else begin
						nxt_q       <= link_hold_q;
						nxt_delta_q <= rd_delta;
						state_q     <= ST_INS_FIX1;
					end
				end
				ST_INS_FIX1: begin
					d_q     <= dz_w;
					state_q <= ST_INS_FIX2;
				end
				ST_INS_FIX2: begin
					state_q <= ins_exp_q ? ST_EXP_NEXT : ST_IDLE;
				end
				ST_EXP_FIND: begin
					if (!find_first_q && rd_delta != 32'd0) begin
						last_q  <= cur_q;
						head_q  <= cur_q;
						state_q <= ST_EXP_NODE;
					end else if (rd_link == NONE_IDX) begin
						last_q  <= NONE_IDX;
						head_q  <= NONE_IDX;
						state_q <= ST_EXP_NODE;
					end else begin
						cur_q        <= rd_link;
						find_first_q <= 1'b0;
					end
				end
				ST_EXP_NODE: begin
					state_q <= ST_EXP_NODED;
				end
				ST_EXP_NODED: begin
					node_nxt_q <= rd_link;
					node_per_q <= (rd_period != 32'd0);
					due_new_q  <= rd_due + {32'd0, rd_period};
					if (hit) begin
						mbits_q[hidx] <= mbits_q[hidx] | rd_mask;
					end else if (mcnt_q < CNT_W'(COALESCE)) begin
						mth_q[mcnt_q[CI_W-1:0]]   <= rd_thread;
						mbits_q[mcnt_q[CI_W-1:0]] <= rd_mask;
						mcnt_q <= mcnt_q + CNT_W'(1);
					end else begin
						rsp_valid_q         <= 1'b1;
						rsp_q.kind          <= KIND_NOTIFY;
						rsp_q.slot          <= 4'd0;
						rsp_q.target_thread <= rd_thread;
						rsp_q.bits_out      <= rd_mask;
						rsp_q.last          <= 1'b0;
					end
					state_q <= ST_EXP_RET;
				end
				ST_EXP_RET: begin
					if (node_per_q && ret_w != 32'd0) begin
						ins_k_q   <= ev_q;
						ins_t_q   <= ret_w;
						ins_exp_q <= 1'b1;
						state_q   <= ST_INS_START;
					end else begin
						used_q[ev_q[SLOT_W-1:0]] <= 1'b0;
						state_q <= ST_EXP_NEXT;
					end
				end
				ST_EXP_NEXT: begin
					if (node_nxt_q != NONE_IDX && node_nxt_q != last_q) begin
						ev_q    <= node_nxt_q;
						state_q <= ST_EXP_NODE;
					end else begin
						fl_idx_q <= '0;
						state_q  <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					rsp_valid_q         <= 1'b1;
					rsp_q.kind          <= KIND_NOTIFY;
					rsp_q.slot          <= 4'd0;
					rsp_q.target_thread <= mth_q[fl_idx_q[CI_W-1:0]];
					rsp_q.bits_out      <= mbits_q[fl_idx_q[CI_W-1:0]];
					rsp_q.last          <= (fl_idx_q + CNT_W'(1) == mcnt_q);
					fl_idx_q            <= fl_idx_q + CNT_W'(1);
					if (fl_idx_q + CNT_W'(1) == mcnt_q) begin
						mcnt_q  <= '0;
						state_q <= ST_ARM;
					end
				end
				ST_ARM: begin
					state_q <= (head_q == NONE_IDX) ? ST_IDLE : ST_ARM_D;
				end
				ST_ARM_D: begin
					countdown_q <= (rd_delta != 32'd0) ? rd_delta : 32'd1;
					elapsed_q   <= 32'd0;
					running_q   <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/dltq_chk.sv =====
module dltq_chk
	import dltq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic rsp_valid,
	input rsp_t rsp
);

	// A create answers with exactly one word in the next cycle.
	a_create_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.cmd == CMD_CREATE |=>
		rsp_valid && rsp.last && (rsp.kind == KIND_ACCEPT || rsp.kind == KIND_REJECT))
		else $error("create word not answered in the next cycle");

	// A tick never answers in the cycle right after it is taken.
	a_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.cmd == CMD_TICK |=> !rsp_valid)
		else $error("tick answered too early");

	// Notifications only go to real threads with real bits.
	a_notify_payload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_NOTIFY |->
		rsp.target_thread != 8'd0 && rsp.bits_out != 32'd0 && rsp.slot == 4'd0)
		else $error("empty notification");

	// Every result word carries one of the three defined kinds.
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.kind == KIND_ACCEPT || rsp.kind == KIND_REJECT ||
		rsp.kind == KIND_NOTIFY))
		else $error("illegal result kind");

endmodule

bind delta_list_timer_queue_top dltq_chk u_dltq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp       (rsp)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import dltq_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        rsp_valid;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int QUIET_CYCLES   = 200;

	always #5 clk = ~clk;

	delta_list_timer_queue_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.rsp_valid(rsp_valid), .rsp(rsp), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	class timer_scoreboard;
		bit [15:0]  min_ticks;
		bit         used [SLOTS];
		int         link [SLOTS];
		bit [31:0]  delta [SLOTS];
		bit [7:0]   thr [SLOTS];
		bit [31:0]  mask [SLOTS];
		bit [31:0]  period [SLOTS];
		bit [63:0]  due [SLOTS];
		int         head;
		bit [63:0]  now;
		bit [31:0]  countdown;
		bit [31:0]  elapsed;
		bit         running;
		rsp_t       pending [$];
		rsp_t       burst [$];
		int         mismatches;
		int         free_slots;

		function void clear();
			min_ticks = 16'd1;
			foreach (used[i]) used[i] = 1'b0;
			head = SLOTS;
			now = '0;
			countdown = '0;
			elapsed = '0;
			running = 1'b0;
			pending.delete();
			mismatches = 0;
			free_slots = SLOTS;
		endfunction

		function void arm(bit [31:0] d);
			countdown = d;
			elapsed = '0;
			running = 1'b1;
		endfunction

		function void add(bit [1:0] kind, bit [3:0] slot, bit [7:0] t, bit [31:0] b);
			rsp_t r;
			if (burst.size() >= 16) return;
			r.kind = kind;
			r.slot = slot;
			r.target_thread = t;
			r.bits_out = b;
			r.last = 1'b0;
			burst.push_back(r);
		endfunction

		function void link_in(bit [31:0] t_in, int k);
			bit [31:0] t;
			int nxt, ev, guard;
			bit [63:0] d, et;
			t = t_in;
			if (t <= elapsed) t = 1;
			else t -= elapsed;
			link[k] = SLOTS;
			if (head >= SLOTS) begin
				delta[k] = t;
				head = k;
				arm(t);
				return;
			end
			nxt = head;
			ev = head;
			d = '0;
			if (t >= delta[head]) begin
				et = '0;
				guard = 0;
				do begin
					ev = nxt;
					et += delta[ev];
					d = {32'd0, t} - et;
					nxt = link[ev];
					guard++;
				end while (nxt < SLOTS && guard < SLOTS &&
						{32'd0, t} > et + {32'd0, delta[nxt]});
				link[ev] = k;
			end else begin
				head = k;
				d = t;
				arm(t);
			end
			if (d < {48'd0, min_ticks}) d = '0;
			link[k] = nxt;
			delta[k] = d[31:0];
			if (nxt < SLOTS) delta[nxt] -= d[31:0];
		endfunction

		function void fire();
			bit [7:0]  m_thr [$];
			bit [31:0] m_bits [$];
			int ev, nxt, stop, guard;
			bit [31:0] ret;
			bit found;
			if (head >= SLOTS) begin
				running = 1'b0;
				return;
			end
			ev = head;
			guard = 0;
			do begin
				ev = link[ev];
				guard++;
			end while (ev < SLOTS && guard < SLOTS && delta[ev] == 0);
			stop = ev;
			ev = head;
			head = stop;
			guard = 0;
			do begin
				found = 1'b0;
				foreach (m_thr[i]) begin
					if (!found && m_thr[i] == thr[ev]) begin
						m_bits[i] |= mask[ev];
						found = 1'b1;
					end
				end
				if (!found) begin
					if (m_thr.size() < COALESCE) begin
						m_thr.push_back(thr[ev]);
						m_bits.push_back(mask[ev]);
					end else begin
						add(KIND_NOTIFY, 4'd0, thr[ev], mask[ev]);
					end
				end
				ret = '0;
				if (period[ev] != 0) begin
					due[ev] += period[ev];
					ret = due[ev] > now ? 32'(due[ev] - now) : 32'd1;
				end
				nxt = link[ev];
				if (ret != 0) link_in(ret, ev);
				else begin
					used[ev] = 1'b0;
					free_slots++;
				end
				ev = nxt;
				guard++;
			end while (nxt < SLOTS && nxt != stop && guard < SLOTS);
			foreach (m_thr[i]) add(KIND_NOTIFY, 4'd0, m_thr[i], m_bits[i]);
			if (head < SLOTS) arm(delta[head] != 0 ? delta[head] : 32'd1);
		endfunction

		function void note_word(req_t w);
			int k;
			burst.delete();
			if (w.cmd == CMD_CREATE) begin
				k = SLOTS;
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!used[i]) k = i;
				if (w.ticks == 0 || w.thread_id == 0 || w.wake_mask == 0 || k >= SLOTS) begin
					add(KIND_REJECT, 4'd0, 8'd0, 32'd0);
				end else begin
					used[k] = 1'b1;
					free_slots--;
					thr[k] = w.thread_id;
					mask[k] = w.wake_mask;
					period[k] = w.periodic ? w.ticks : 32'd0;
					due[k] = w.periodic ? now + w.ticks : 64'd0;
					link_in(w.ticks, k);
					add(KIND_ACCEPT, 4'(k), 8'd0, 32'd0);
				end
			end else begin
				now++;
				if (running && countdown > 0) begin
					elapsed++;
					countdown--;
					if (countdown == 0) begin
						running = 1'b0;
						elapsed = '0;
						fire();
					end
				end
			end
			if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
			foreach (burst[i]) pending.push_back(burst[i]);
		endfunction

		function void check_word(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	timer_scoreboard sb;
	int  idle_cycles = 0;
	bit  gaps_on;

	always @(posedge clk) begin
		if (arst_n && rsp_valid) sb.check_word(rsp);
		if (arst_n && ((start && !busy) || rsp_valid || (cfg_valid && cfg_ready)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic random_gap();
		int n;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_word(req_t w);
		random_gap();
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		sb.note_word(w);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_ticks(bit [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.min_ticks = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic req_t make_create(bit [31:0] t, bit [7:0] th, bit [31:0] b, bit p);
		req_t w;
		w.cmd = CMD_CREATE;
		w.ticks = t;
		w.thread_id = th;
		w.wake_mask = b;
		w.periodic = p;
		return w;
	endfunction

	function automatic req_t make_tick();
		req_t w;
		w = '0;
		w.cmd = CMD_TICK;
		w.ticks = $urandom;
		w.thread_id = $urandom;
		w.wake_mask = $urandom;
		w.periodic = $urandom;
		return w;
	endfunction

	function automatic req_t random_create();
		bit [31:0] t;
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 3);
		else if (sel == 1) t = $urandom;
		else if (sel == 2) t = 0;
		else t = $urandom_range(1, 12);
		return make_create(t, ($urandom_range(0, 25) == 0) ? 8'd0 : 8'($urandom_range(1, 12)),
			($urandom_range(0, 25) == 0) ? 32'd0 : 32'($urandom),
			$urandom_range(0, 2) == 0);
	endfunction

	initial begin
		bit [15:0] setting;
		sb = new();
		sb.clear();
		gaps_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(make_create(32'd0, 8'd1, 32'd1, 1'b0));
		send_word(make_create(32'd5, 8'd0, 32'd1, 1'b0));
		send_word(make_create(32'd5, 8'd1, 32'd0, 1'b0));
		send_word(make_create(32'd3, 8'd255, 32'hFFFF_FFFF, 1'b1));
		send_word(make_create(32'd3, 8'd255, 32'h0000_0001, 1'b0));
		send_word(make_create(32'd1, 8'd7, 32'h8000_0000, 1'b1));
		send_word(make_create(32'hFFFF_FFFF, 8'd9, 32'h5555_AAAA, 1'b1));
		for (int i = 0; i < 12; i++)
			send_word(make_create(32'd2, 8'(i + 20), 32'(1 << i), 1'b0));
		for (int i = 0; i < 6; i++)
			send_word(make_tick());

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: setting = 16'd0;
				1: setting = 16'hFFFF;
				2: setting = 16'($urandom_range(2, 5));
				default: setting = 16'd1;
			endcase
			write_min_ticks(setting);
			if (phase == 3) gaps_on = 1'b0;
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(0, 2) == 0 || sb.free_slots == 0 && $urandom_range(0, 3) != 0)
					send_word(random_create());
				else
					send_word(make_tick());
			end
		end

		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
